FILE: src/gss_pkg.sv
// Shared types, register map and constants for the gantry stepper sequencer.
package gss_pkg;

	localparam int HOME_SQUARES_DEF = 14;
	localparam int COUNT_WIDTH_DEF  = 16;

	// wide enough for any steps-per-square times home squares product
	localparam int PROD_W = 20;

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// command codes
	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_MOVE  = 3'd1;
	localparam logic [2:0] KIND_HOME  = 3'd2;
	localparam logic [2:0] KIND_RAISE = 3'd3;
	localparam logic [2:0] KIND_LOWER = 3'd4;

	// register indexes
	localparam logic [2:0] REG_X_SPS      = 3'd0;
	localparam logic [2:0] REG_Y_SPS      = 3'd1;
	localparam logic [2:0] REG_Z_TRAVEL   = 3'd2;
	localparam logic [2:0] REG_X_OFFSET   = 3'd3;
	localparam logic [2:0] REG_Y_OFFSET   = 3'd4;
	localparam logic [2:0] REG_X_HALF     = 3'd5;
	localparam logic [2:0] REG_Y_HALF     = 3'd6;
	localparam logic [2:0] REG_Z_HALF     = 3'd7;

	localparam logic [11:0] X_SPS_RST    = 12'd100;
	localparam logic [11:0] Y_SPS_RST    = 12'd100;
	localparam logic [14:0] Z_TRAVEL_RST = 15'd400;
	localparam logic [11:0] X_OFFSET_RST = 12'd0;
	localparam logic [11:0] Y_OFFSET_RST = 12'd0;
	localparam logic [7:0]  X_HALF_RST   = 8'd6;
	localparam logic [7:0]  Y_HALF_RST   = 8'd18;
	localparam logic [7:0]  Z_HALF_RST   = 8'd1;

	localparam logic [3:0] POS_X_RST = 4'd3;
	localparam logic [3:0] POS_Y_RST = 4'd0;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_MOVE_X  = 4'd1,
		PH_MOVE_Y  = 4'd2,
		PH_HOME_Z  = 4'd3,
		PH_HY_SEEK = 4'd4,
		PH_HY_BACK = 4'd5,
		PH_HX_SEEK = 4'd6,
		PH_HX_BACK = 4'd7,
		PH_RAISE   = 4'd8,
		PH_LOWER   = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} axis_t;

	typedef struct packed {
		logic [11:0] x_steps_per_square;
		logic [11:0] y_steps_per_square;
		logic [14:0] z_travel_steps;
		logic [11:0] x_home_offset;
		logic [11:0] y_home_offset;
		logic [7:0]  x_half_period;
		logic [7:0]  y_half_period;
		logic [7:0]  z_half_period;
	} cfg_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] target_x;
		logic [3:0] target_y;
		logic       home_x_switch;
		logic       home_y_switch;
		logic       top_z_switch;
	} cmd_t;

	typedef struct packed {
		logic       x_step;
		logic       x_dir;
		logic       x_enable;
		logic       y_step;
		logic       y_dir;
		logic       y_enable;
		logic       z_step;
		logic       z_dir;
		logic       z_enable;
		logic       busy_res;
		logic [3:0] pos_x_out;
		logic [3:0] pos_y_out;
	} res_t;

	function automatic axis_t axis_of(input phase_t ph);
		axis_t ax;
		ax = AX_Z;
		if (ph == PH_MOVE_X || ph == PH_HX_SEEK || ph == PH_HX_BACK)
			ax = AX_X;
		else if (ph == PH_MOVE_Y || ph == PH_HY_SEEK || ph == PH_HY_BACK)
			ax = AX_Y;
		return ax;
	endfunction

endpackage

FILE: src/gantry_stepper_sequencer.sv
// Top level of the gantry stepper sequencer: handshake pipeline around the sequencer.
// Drives three step/dir/enable stepper axes. Each input transaction is a command (move,
// home, raise Z, lower Z) or a timer tick, and yields exactly one result transaction
// with the pin levels, busy flag and tracked square position after it. Commands are
// taken only while idle; commands while busy and ticks while idle change nothing.
// One transaction is accepted per clock cycle when the output side keeps up. A command
// passes the input register, then the result register fed by the combinational sequencer update.
// Configuration must be written over APB only while the block is idle; the block does not enforce it.
module gantry_stepper_sequencer #(
	parameter int HOME_SQUARES = gss_pkg::HOME_SQUARES_DEF,
	parameter int COUNT_WIDTH  = gss_pkg::COUNT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  gss_pkg::cmd_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output gss_pkg::res_t               out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gss_pkg::APB_AW-1:0]  paddr,
	input  logic [gss_pkg::APB_DW-1:0]  pwdata,
	output logic [gss_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	gss_pkg::cfg_t cfg;
	gss_pkg::cmd_t cmd_s1;
	gss_pkg::res_t res_next;
	logic          valid_s1;
	logic          out_valid_q;
	logic          advance;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;

	gss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gss_seq #(
		.HOME_SQUARES (HOME_SQUARES),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.cmd     (cmd_s1),
		.cfg     (cfg),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			cmd_s1 <= in_data;
		if (advance)
			out_data <= res_next;
	end

endmodule

FILE: src/gss_regs.sv
// APB configuration register file for the gantry stepper sequencer.
module gss_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gss_pkg::APB_AW-1:0]   paddr,
	input  logic [gss_pkg::APB_DW-1:0]   pwdata,
	output logic [gss_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output gss_pkg::cfg_t                cfg
);

	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.x_steps_per_square <= gss_pkg::X_SPS_RST;
			cfg.y_steps_per_square <= gss_pkg::Y_SPS_RST;
			cfg.z_travel_steps     <= gss_pkg::Z_TRAVEL_RST;
			cfg.x_home_offset      <= gss_pkg::X_OFFSET_RST;
			cfg.y_home_offset      <= gss_pkg::Y_OFFSET_RST;
			cfg.x_half_period      <= gss_pkg::X_HALF_RST;
			cfg.y_half_period      <= gss_pkg::Y_HALF_RST;
			cfg.z_half_period      <= gss_pkg::Z_HALF_RST;
		end else if (wr_en) begin
			unique case (idx)
				gss_pkg::REG_X_SPS:    cfg.x_steps_per_square <= pwdata[11:0];
				gss_pkg::REG_Y_SPS:    cfg.y_steps_per_square <= pwdata[11:0];
				gss_pkg::REG_Z_TRAVEL: cfg.z_travel_steps     <= pwdata[14:0];
				gss_pkg::REG_X_OFFSET: cfg.x_home_offset      <= pwdata[11:0];
				gss_pkg::REG_Y_OFFSET: cfg.y_home_offset      <= pwdata[11:0];
				gss_pkg::REG_X_HALF:   cfg.x_half_period      <= pwdata[7:0];
				gss_pkg::REG_Y_HALF:   cfg.y_half_period      <= pwdata[7:0];
				gss_pkg::REG_Z_HALF:   cfg.z_half_period      <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			gss_pkg::REG_X_SPS:    prdata = 32'(cfg.x_steps_per_square);
			gss_pkg::REG_Y_SPS:    prdata = 32'(cfg.y_steps_per_square);
			gss_pkg::REG_Z_TRAVEL: prdata = 32'(cfg.z_travel_steps);
			gss_pkg::REG_X_OFFSET: prdata = 32'(cfg.x_home_offset);
			gss_pkg::REG_Y_OFFSET: prdata = 32'(cfg.y_home_offset);
			gss_pkg::REG_X_HALF:   prdata = 32'(cfg.x_half_period);
			gss_pkg::REG_Y_HALF:   prdata = 32'(cfg.y_half_period);
			gss_pkg::REG_Z_HALF:   prdata = 32'(cfg.z_half_period);
		endcase
	end

endmodule

FILE: src/gss_seq.sv
// Sequencer state and per-transaction next-state / pin logic.
module gss_seq #(
	parameter int HOME_SQUARES = gss_pkg::HOME_SQUARES_DEF,
	parameter int COUNT_WIDTH  = gss_pkg::COUNT_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step_en,
	input  gss_pkg::cmd_t  cmd,
	input  gss_pkg::cfg_t  cfg,
	output gss_pkg::res_t  res
);

	localparam int PW = gss_pkg::PROD_W;

	gss_pkg::phase_t        phase_q, n_phase;
	logic [COUNT_WIDTH-1:0] step_q, n_step;
	logic [7:0]             tick_q, n_tick;
	logic                   pulse_q, n_pulse;
	logic [3:0]             pos_x_q, n_pos_x;
	logic [3:0]             pos_y_q, n_pos_y;
	logic [3:0]             goal_x_q, n_goal_x;
	logic [3:0]             goal_y_q, n_goal_y;
	logic [2:0]             dir_q, n_dir;
	logic [2:0]             en_q, n_en;

	function automatic logic [COUNT_WIDTH-1:0] sat(input logic [PW-1:0] v);
		logic [COUNT_WIDTH-1:0] r;
		r = COUNT_WIDTH'(v);
		if ((32'(v) >> COUNT_WIDTH) != 32'd0)
			r = '1;
		return r;
	endfunction

	// next state
	always_comb begin : next_state
		logic            ent;
		gss_pkg::phase_t ent_ph;
		logic [PW-1:0]   ent_cnt;
		logic            ent_dir;
		logic            to_idle;
		logic            hit;
		logic [7:0]      half;
		logic [3:0]      gx, gy, dx, dy;
		gss_pkg::axis_t  ax;
		gss_pkg::axis_t  ent_ax;
		logic            y_ent;
		logic [PW-1:0]   y_cnt;

		n_phase  = phase_q;
		n_step   = step_q;
		n_tick   = tick_q;
		n_pulse  = pulse_q;
		n_pos_x  = pos_x_q;
		n_pos_y  = pos_y_q;
		n_goal_x = goal_x_q;
		n_goal_y = goal_y_q;
		n_dir    = dir_q;
		n_en     = en_q;
		ent      = 1'b0;
		ent_ph   = gss_pkg::PH_IDLE;
		ent_cnt  = '0;
		ent_dir  = 1'b0;
		to_idle  = 1'b0;
		hit      = 1'b0;

		gx = (phase_q == gss_pkg::PH_IDLE) ? cmd.target_x : goal_x_q;
		gy = (phase_q == gss_pkg::PH_IDLE) ? cmd.target_y : goal_y_q;
		dx = (gx > pos_x_q) ? gx - pos_x_q : pos_x_q - gx;
		dy = (gy > pos_y_q) ? gy - pos_y_q : pos_y_q - gy;
		y_ent = (gy != pos_y_q);
		y_cnt = PW'(dy) * PW'(cfg.y_steps_per_square);

		ax = gss_pkg::axis_of(phase_q);
		unique case (ax)
			gss_pkg::AX_X: half = cfg.x_half_period;
			gss_pkg::AX_Y: half = cfg.y_half_period;
			default:       half = cfg.z_half_period;
		endcase

		if (phase_q == gss_pkg::PH_IDLE) begin
			priority if (cmd.kind == gss_pkg::KIND_MOVE) begin
				n_goal_x = cmd.target_x;
				n_goal_y = cmd.target_y;
				if (gx != pos_x_q) begin
					ent     = 1'b1;
					ent_ph  = gss_pkg::PH_MOVE_X;
					ent_cnt = PW'(dx) * PW'(cfg.x_steps_per_square);
					ent_dir = (gx < pos_x_q);
				end else if (y_ent) begin
					ent     = 1'b1;
					ent_ph  = gss_pkg::PH_MOVE_Y;
					ent_cnt = y_cnt;
					ent_dir = (gy > pos_y_q);
				end else begin
					n_pos_x = gx;
					to_idle = 1'b1;
				end
			end else if (cmd.kind == gss_pkg::KIND_HOME) begin
				ent     = 1'b1;
				ent_ph  = gss_pkg::PH_HOME_Z;
				ent_cnt = PW'({cfg.z_travel_steps, 1'b0});
			end else if (cmd.kind == gss_pkg::KIND_RAISE) begin
				ent     = 1'b1;
				ent_ph  = gss_pkg::PH_RAISE;
				ent_cnt = PW'({cfg.z_travel_steps, 1'b0});
			end else if (cmd.kind == gss_pkg::KIND_LOWER) begin
				ent     = 1'b1;
				ent_ph  = gss_pkg::PH_LOWER;
				ent_cnt = PW'(cfg.z_travel_steps);
				ent_dir = 1'b1;
			end else begin
				ent = 1'b0;
			end
		end else if (cmd.kind == gss_pkg::KIND_TICK) begin
			if (phase_q == gss_pkg::PH_HOME_Z || phase_q == gss_pkg::PH_RAISE)
				hit = cmd.top_z_switch;
			else if (phase_q == gss_pkg::PH_HY_SEEK)
				hit = cmd.home_y_switch;
			else if (phase_q == gss_pkg::PH_HX_SEEK)
				hit = cmd.home_x_switch;

			priority if (tick_q > 8'd1) begin
				n_tick = tick_q - 8'd1;
			end else if (pulse_q) begin
				n_pulse = 1'b0;
				n_tick  = half;
			end else if (step_q == '0 || hit) begin
				// segment finished: pick the next one
				unique case (phase_q)
					gss_pkg::PH_MOVE_X: begin
						n_en[gss_pkg::AX_X] = 1'b0;
						if (y_ent) begin
							ent     = 1'b1;
							ent_ph  = gss_pkg::PH_MOVE_Y;
							ent_cnt = y_cnt;
							ent_dir = (gy > pos_y_q);
						end else begin
							n_pos_x = goal_x_q;
							to_idle = 1'b1;
						end
					end
					gss_pkg::PH_MOVE_Y: begin
						n_en[gss_pkg::AX_Y] = 1'b0;
						n_pos_x = goal_x_q;
						n_pos_y = goal_y_q;
						to_idle = 1'b1;
					end
					gss_pkg::PH_HOME_Z: begin
						n_en[gss_pkg::AX_Z] = 1'b0;
						ent     = 1'b1;
						ent_ph  = gss_pkg::PH_HY_SEEK;
						ent_cnt = PW'(cfg.y_steps_per_square) * PW'(HOME_SQUARES);
					end
					gss_pkg::PH_HY_SEEK: begin
						ent     = 1'b1;
						ent_ph  = gss_pkg::PH_HY_BACK;
						ent_cnt = PW'(cfg.y_home_offset);
						ent_dir = 1'b1;
					end
					gss_pkg::PH_HY_BACK: begin
						n_en[gss_pkg::AX_Y] = 1'b0;
						ent     = 1'b1;
						ent_ph  = gss_pkg::PH_HX_SEEK;
						ent_cnt = PW'(cfg.x_steps_per_square) * PW'(HOME_SQUARES);
						ent_dir = 1'b1;
					end
					gss_pkg::PH_HX_SEEK: begin
						ent     = 1'b1;
						ent_ph  = gss_pkg::PH_HX_BACK;
						ent_cnt = PW'(cfg.x_home_offset);
					end
					gss_pkg::PH_HX_BACK: begin
						n_en[gss_pkg::AX_X] = 1'b0;
						n_pos_x = '0;
						n_pos_y = '0;
						to_idle = 1'b1;
					end
					default: begin
						// raise, lower, or Z limit stop
						n_en[gss_pkg::AX_Z] = 1'b0;
						to_idle = 1'b1;
					end
				endcase
			end else begin
				n_step  = step_q - 1'b1;
				n_pulse = 1'b1;
				n_tick  = half;
			end
		end

		ent_ax = gss_pkg::axis_of(ent_ph);
		if (ent) begin
			n_phase        = ent_ph;
			n_step         = sat(ent_cnt);
			n_pulse        = 1'b0;
			n_tick         = '0;
			n_dir[ent_ax]  = ent_dir;
			n_en[ent_ax]   = 1'b1;
		end else if (to_idle) begin
			n_phase = gss_pkg::PH_IDLE;
			n_step  = '0;
			n_tick  = '0;
			n_pulse = 1'b0;
		end
	end

	// pin levels after this transaction
	always_comb begin : pin_out
		gss_pkg::axis_t oax;
		logic           act;
		oax = gss_pkg::axis_of(n_phase);
		act = (n_phase != gss_pkg::PH_IDLE);
		res.x_step    = act && oax == gss_pkg::AX_X && n_pulse;
		res.y_step    = act && oax == gss_pkg::AX_Y && n_pulse;
		res.z_step    = act && oax == gss_pkg::AX_Z && n_pulse;
		res.x_dir     = n_dir[0];
		res.y_dir     = n_dir[1];
		res.z_dir     = n_dir[2];
		res.x_enable  = n_en[0];
		res.y_enable  = n_en[1];
		res.z_enable  = n_en[2];
		res.busy_res  = act;
		res.pos_x_out = n_pos_x;
		res.pos_y_out = n_pos_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gss_pkg::PH_IDLE;
			step_q  <= '0;
			tick_q  <= '0;
			pulse_q <= 1'b0;
			pos_x_q <= gss_pkg::POS_X_RST;
			pos_y_q <= gss_pkg::POS_Y_RST;
			dir_q   <= '0;
			en_q    <= '0;
		end else if (step_en) begin
			phase_q <= n_phase;
			step_q  <= n_step;
			tick_q  <= n_tick;
			pulse_q <= n_pulse;
			pos_x_q <= n_pos_x;
			pos_y_q <= n_pos_y;
			dir_q   <= n_dir;
			en_q    <= n_en;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			goal_x_q <= n_goal_x;
			goal_y_q <= n_goal_y;
		end
	end

`ifndef SYNTHESIS
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == gss_pkg::PH_IDLE |-> !pulse_q && step_q == '0 && tick_q == '0)
		else $error("idle with pulse or counters pending");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(phase_q) && $stable(step_q) && $stable(pos_x_q))
		else $error("state changed without a transaction");

	a_tick_idle_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == gss_pkg::PH_IDLE && cmd.kind == gss_pkg::KIND_TICK
		|=> phase_q == gss_pkg::PH_IDLE && $stable(en_q))
		else $error("tick while idle started motion");

	a_busy_cmd_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q != gss_pkg::PH_IDLE && cmd.kind != gss_pkg::KIND_TICK
		|=> $stable(phase_q) && $stable(step_q) && $stable(tick_q))
		else $error("command while busy changed state");
`endif

endmodule

FILE: test/gss_checker.sv
// Checker for the gantry stepper sequencer: predicts each result and compares it.
module gss_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  gss_pkg::cmd_t               in_data,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  gss_pkg::res_t               out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gss_pkg::APB_AW-1:0]  paddr,
	input  logic [gss_pkg::APB_DW-1:0]  pwdata,
	input  logic                        pready,
	output int                          mismatches,
	output int                          pending,
	output logic                        motion_busy
);
	import gss_pkg::*;

	localparam int RAISE_FACTOR = 2;
	localparam int COUNT_MAX    = (1 << COUNT_WIDTH_DEF) - 1;

	cfg_t        cfg;
	phase_t      ph;
	logic [15:0] steps_left;
	logic [7:0]  ticks_left;
	logic        pulse;
	logic [3:0]  px, py, gx, gy;
	logic [2:0]  dirs, ens;
	res_t        expected_pins[$];

	function automatic axis_t phase_axis(input phase_t p);
		case (p)
			PH_MOVE_X, PH_HX_SEEK, PH_HX_BACK: return AX_X;
			PH_MOVE_Y, PH_HY_SEEK, PH_HY_BACK: return AX_Y;
			default: return AX_Z;
		endcase
	endfunction

	task automatic seg_begin(input phase_t p, input int count, input logic d);
		axis_t a;
		a = phase_axis(p);
		ph = p;
		steps_left = (count > COUNT_MAX) ? 16'(COUNT_MAX) : 16'(count);
		pulse = 1'b0;
		ticks_left = '0;
		dirs[a] = d;
		ens[a] = 1'b1;
	endtask

	task automatic seg_park();
		ph = PH_IDLE;
		steps_left = '0;
		ticks_left = '0;
		pulse = 1'b0;
	endtask

	task automatic y_leg_or_done();
		if (gy > py)
			seg_begin(PH_MOVE_Y, (int'(gy) - int'(py)) * int'(cfg.y_steps_per_square), 1'b1);
		else if (gy < py)
			seg_begin(PH_MOVE_Y, (int'(py) - int'(gy)) * int'(cfg.y_steps_per_square), 1'b0);
		else begin
			px = gx;
			seg_park();
		end
	endtask

	task automatic seg_end();
		case (ph)
			PH_MOVE_X: begin
				ens[AX_X] = 1'b0;
				y_leg_or_done();
			end
			PH_MOVE_Y: begin
				ens[AX_Y] = 1'b0;
				px = gx;
				py = gy;
				seg_park();
			end
			PH_HOME_Z: begin
				ens[AX_Z] = 1'b0;
				seg_begin(PH_HY_SEEK, int'(cfg.y_steps_per_square) * HOME_SQUARES_DEF, 1'b0);
			end
			PH_HY_SEEK: seg_begin(PH_HY_BACK, int'(cfg.y_home_offset), 1'b1);
			PH_HY_BACK: begin
				ens[AX_Y] = 1'b0;
				seg_begin(PH_HX_SEEK, int'(cfg.x_steps_per_square) * HOME_SQUARES_DEF, 1'b1);
			end
			PH_HX_SEEK: seg_begin(PH_HX_BACK, int'(cfg.x_home_offset), 1'b0);
			PH_HX_BACK: begin
				ens[AX_X] = 1'b0;
				px = '0;
				py = '0;
				seg_park();
			end
			// raise, lower; a Z limit stop drops enable too
			default: begin
				ens[AX_Z] = 1'b0;
				seg_park();
			end
		endcase
	endtask

	task automatic tick_step(input cmd_t c);
		axis_t      a;
		logic [7:0] half;
		logic       hit;
		a = phase_axis(ph);
		case (a)
			AX_X: half = cfg.x_half_period;
			AX_Y: half = cfg.y_half_period;
			default: half = cfg.z_half_period;
		endcase
		hit = 1'b0;
		if (ticks_left > 8'd1) begin
			ticks_left--;
			return;
		end
		if (pulse) begin
			pulse = 1'b0;
			ticks_left = half;
			return;
		end
		// seeking segments look at their switch before every step
		if (ph == PH_HOME_Z || ph == PH_RAISE)
			hit = c.top_z_switch;
		else if (ph == PH_HY_SEEK)
			hit = c.home_y_switch;
		else if (ph == PH_HX_SEEK)
			hit = c.home_x_switch;
		if (steps_left == '0 || hit) begin
			seg_end();
			return;
		end
		steps_left--;
		pulse = 1'b1;
		ticks_left = half;
	endtask

	function automatic res_t pins();
		res_t  r;
		axis_t a;
		a = phase_axis(ph);
		r.x_step    = (ph != PH_IDLE && a == AX_X) ? pulse : 1'b0;
		r.x_dir     = dirs[AX_X];
		r.x_enable  = ens[AX_X];
		r.y_step    = (ph != PH_IDLE && a == AX_Y) ? pulse : 1'b0;
		r.y_dir     = dirs[AX_Y];
		r.y_enable  = ens[AX_Y];
		r.z_step    = (ph != PH_IDLE && a == AX_Z) ? pulse : 1'b0;
		r.z_dir     = dirs[AX_Z];
		r.z_enable  = ens[AX_Z];
		r.busy_res  = (ph != PH_IDLE);
		r.pos_x_out = px;
		r.pos_y_out = py;
		return r;
	endfunction

	task automatic accept_cmd(input cmd_t c);
		if (ph == PH_IDLE) begin
			case (c.kind)
				KIND_MOVE: begin
					gx = c.target_x;
					gy = c.target_y;
					if (gx > px)
						seg_begin(PH_MOVE_X,
							(int'(gx) - int'(px)) * int'(cfg.x_steps_per_square), 1'b0);
					else if (gx < px)
						seg_begin(PH_MOVE_X,
							(int'(px) - int'(gx)) * int'(cfg.x_steps_per_square), 1'b1);
					else
						y_leg_or_done();
				end
				KIND_HOME:  seg_begin(PH_HOME_Z, RAISE_FACTOR * int'(cfg.z_travel_steps), 1'b0);
				KIND_RAISE: seg_begin(PH_RAISE, RAISE_FACTOR * int'(cfg.z_travel_steps), 1'b0);
				KIND_LOWER: seg_begin(PH_LOWER, int'(cfg.z_travel_steps), 1'b1);
				default: ;
			endcase
		end else if (c.kind == KIND_TICK) begin
			tick_step(c);
		end
		expected_pins.push_back(pins());
	endtask

	function automatic void check_bit(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			cfg = '{X_SPS_RST, Y_SPS_RST, Z_TRAVEL_RST, X_OFFSET_RST, Y_OFFSET_RST,
				X_HALF_RST, Y_HALF_RST, Z_HALF_RST};
			seg_park();
			px = POS_X_RST;
			py = POS_Y_RST;
			gx = '0;
			gy = '0;
			dirs = '0;
			ens = '0;
			expected_pins.delete();
			mismatches = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_pins.size() == 0) begin
					$error("result transaction with nothing expected: %p", out_data);
					mismatches++;
				end else begin
					want = expected_pins.pop_front();
					check_bit("x_step", want.x_step, out_data.x_step);
					check_bit("x_dir", want.x_dir, out_data.x_dir);
					check_bit("x_enable", want.x_enable, out_data.x_enable);
					check_bit("y_step", want.y_step, out_data.y_step);
					check_bit("y_dir", want.y_dir, out_data.y_dir);
					check_bit("y_enable", want.y_enable, out_data.y_enable);
					check_bit("z_step", want.z_step, out_data.z_step);
					check_bit("z_dir", want.z_dir, out_data.z_dir);
					check_bit("z_enable", want.z_enable, out_data.z_enable);
					check_bit("busy_res", want.busy_res, out_data.busy_res);
					check_bit("pos_x_out", want.pos_x_out, out_data.pos_x_out);
					check_bit("pos_y_out", want.pos_y_out, out_data.pos_y_out);
				end
			end
			if (in_valid && in_ready)
				accept_cmd(in_data);
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_X_SPS:    cfg.x_steps_per_square = pwdata[11:0];
					REG_Y_SPS:    cfg.y_steps_per_square = pwdata[11:0];
					REG_Z_TRAVEL: cfg.z_travel_steps     = pwdata[14:0];
					REG_X_OFFSET: cfg.x_home_offset      = pwdata[11:0];
					REG_Y_OFFSET: cfg.y_home_offset      = pwdata[11:0];
					REG_X_HALF:   cfg.x_half_period      = pwdata[7:0];
					REG_Y_HALF:   cfg.y_half_period      = pwdata[7:0];
					default:      cfg.z_half_period      = pwdata[7:0];
				endcase
			end
		end
		pending = expected_pins.size();
		motion_busy = (ph != PH_IDLE);
	end

endmodule

FILE: test/gantry_stepper_sequencer_test.sv
// Testbench top for the gantry stepper sequencer: stimulus, configuration and verdict.
module gantry_stepper_sequencer_test;
	import gss_pkg::*;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int RANDOM_ITEMS    = 850;
	localparam int HOLD_OFF_CYCLES = 400;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	cmd_t                in_data;
	logic                out_valid;
	logic                out_ready;
	res_t                out_data;
	logic                psel, penable, pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	int   mismatches;
	int   pending;
	logic motion_busy;

	int   tx_gap_pct = 5;
	int   rx_stall_pct = 5;
	bit   stall_req = 1'b0;
	int   items_sent = 0;
	int   cycles = 0;
	int   trip_choices[4] = '{0, 3, 15, 60};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	gantry_stepper_sequencer u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	gss_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .pending(pending), .motion_busy(motion_busy)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic cmd_t make_cmd(input logic [2:0] k, input logic [3:0] tx,
			input logic [3:0] ty, input logic [2:0] sw);
		cmd_t c;
		c.kind = k;
		c.target_x = tx;
		c.target_y = ty;
		{c.home_x_switch, c.home_y_switch, c.top_z_switch} = sw;
		return c;
	endfunction

	function automatic logic [2:0] switch_levels(input int pct);
		logic [2:0] s;
		foreach (s[i])
			s[i] = ($urandom_range(0, 99) < pct);
		return s;
	endfunction

	// receiver: random back-pressure plus a long hold-off whenever one is requested
	initial begin
		int hold;
		hold = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				stall_req = 1'b0;
			end else if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 99) < rx_stall_pct)
					hold = gap_len();
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic put(input cmd_t c);
		int g;
		g = ($urandom_range(0, 99) < tx_gap_pct) ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_data <= c;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_cfg(input logic [31:0] xs, input logic [31:0] ys, input logic [31:0] zt,
			input logic [31:0] xo, input logic [31:0] yo, input logic [31:0] xh,
			input logic [31:0] yh, input logic [31:0] zh);
		drain();
		cfg_write(REG_X_SPS, xs);
		cfg_write(REG_Y_SPS, ys);
		cfg_write(REG_Z_TRAVEL, zt);
		cfg_write(REG_X_OFFSET, xo);
		cfg_write(REG_Y_OFFSET, yo);
		cfg_write(REG_X_HALF, xh);
		cfg_write(REG_Y_HALF, yh);
		cfg_write(REG_Z_HALF, zh);
	endtask

	// send a command, then send ticks (with occasional stray commands) until the sequence is over
	task automatic issue(input cmd_t c, input int trip_pct);
		cmd_t t;
		put(c);
		while (motion_busy) begin
			if ($urandom_range(0, 99) < 6)
				t = make_cmd($urandom_range(1, 7), $urandom, $urandom, $urandom);
			else
				t = make_cmd(KIND_TICK, $urandom, $urandom, switch_levels(trip_pct));
			put(t);
		end
	endtask

	initial begin
		int   rand_base;
		int   pick;
		bit   stall_done;
		cmd_t c;

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: idle tick, unknown kinds, one short move, a raise
		put(make_cmd(KIND_TICK, 4'hF, 4'hF, 3'b111));
		put(make_cmd(3'd5, 4'h0, 4'hF, 3'b000));
		put(make_cmd(3'd6, 4'hF, 4'h0, 3'b101));
		put(make_cmd(3'd7, 4'h5, 4'hA, 3'b010));
		issue(make_cmd(KIND_MOVE, 4'd2, 4'd0, 3'b000), 20);
		issue(make_cmd(KIND_RAISE, 4'd0, 4'd0, 3'b000), 30);

		load_cfg(2, 3, 4, 2, 1, 1, 2, 1);
		issue(make_cmd(KIND_MOVE, 4'd2, 4'd0, 3'b111), 0);
		stall_req = 1'b1;
		issue(make_cmd(KIND_MOVE, 4'd15, 4'd15, 3'b000), 0);
		issue(make_cmd(KIND_MOVE, 4'd0, 4'd0, 3'b000), 0);
		issue(make_cmd(KIND_MOVE, 4'd0, 4'd5, 3'b000), 0);
		issue(make_cmd(KIND_MOVE, 4'd7, 4'd5, 3'b000), 0);
		issue(make_cmd(KIND_HOME, 4'd0, 4'd0, 3'b000), 0);
		issue(make_cmd(KIND_HOME, 4'd9, 4'd9, 3'b000), 40);
		issue(make_cmd(KIND_RAISE, 4'd0, 4'd0, 3'b000), 0);
		issue(make_cmd(KIND_RAISE, 4'd0, 4'd0, 3'b000), 40);
		issue(make_cmd(KIND_LOWER, 4'd0, 4'd0, 3'b000), 40);

		// largest counts, half period of zero
		load_cfg(4095, 4095, 32767, 4095, 4095, 0, 0, 0);
		issue(make_cmd(KIND_HOME, 4'd0, 4'd0, 3'b000), 60);
		issue(make_cmd(KIND_RAISE, 4'd0, 4'd0, 3'b000), 60);
		issue(make_cmd(KIND_MOVE, 4'd0, 4'd0, 3'b000), 0);

		// smallest counts, longest half periods; upper bus bits must be dropped
		load_cfg(32'hFFFF_F001, 32'h0000_1001, 32'hFFFF_8001, 32'hFFFF_F000, 0,
			32'hABCD_EFFF, 255, 32'h1234_56FF);
		issue(make_cmd(KIND_MOVE, 4'd1, 4'd1, 3'b000), 0);
		issue(make_cmd(KIND_HOME, 4'd0, 4'd0, 3'b000), 100);
		issue(make_cmd(KIND_LOWER, 4'd0, 4'd0, 3'b000), 0);
		issue(make_cmd(KIND_RAISE, 4'd0, 4'd0, 3'b000), 0);

		rand_base = items_sent;
		stall_done = 1'b0;
		load_cfg($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 5),
			$urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 2),
			$urandom_range(0, 2), $urandom_range(0, 2));
		while (items_sent - rand_base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 11) == 0)
				load_cfg($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 5),
					$urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 2),
					$urandom_range(0, 2), $urandom_range(0, 2));
			if (!stall_done && items_sent - rand_base > 300) begin
				stall_req = 1'b1;
				stall_done = 1'b1;
			end
			case ($urandom_range(0, 3))
				0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_gap_pct = 10; rx_stall_pct = 10; end
				2: begin tx_gap_pct = 30; rx_stall_pct = 5;  end
				default: begin tx_gap_pct = 5; rx_stall_pct = 35; end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 45)
				c = make_cmd(KIND_MOVE, $urandom, $urandom, $urandom);
			else if (pick < 65)
				c = make_cmd(KIND_HOME, $urandom, $urandom, $urandom);
			else if (pick < 78)
				c = make_cmd(KIND_RAISE, $urandom, $urandom, $urandom);
			else if (pick < 91)
				c = make_cmd(KIND_LOWER, $urandom, $urandom, $urandom);
			else if (pick < 95)
				c = make_cmd(KIND_TICK, $urandom, $urandom, $urandom);
			else
				c = make_cmd($urandom_range(5, 7), $urandom, $urandom, $urandom);
			issue(c, trip_choices[$urandom_range(0, 3)]);
		end

		drain();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
src/gss_pkg.sv
src/gss_regs.sv
src/gss_seq.sv
src/gantry_stepper_sequencer.sv
test/gss_checker.sv
test/gantry_stepper_sequencer_test.sv
